### design/rdq_pkg.sv
// Package for the ring deque with id position lookup.
// Holds sizes, operation codes and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package rdq_pkg;

   // Slot count of the ring. It must be a power of two so that the pointers wrap
   // by plain binary overflow.
   localparam int DEPTH       = 1024;
   localparam int PTR_BITS    = $clog2(DEPTH);
   localparam int ID_BITS     = 16;
   localparam int ID_COUNT    = 2 ** ID_BITS;
   localparam int VALUE_BITS  = 16;
   localparam int ANSWER_BITS = 16;
   localparam int OP_BITS     = 3;
   localparam int EPOCH_BITS  = 6;
   localparam int TBL_BITS    = EPOCH_BITS + PTR_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH      = 3'd0,
      OP_POP       = 3'd1,
      OP_ID_AT_POS = 3'd2,
      OP_POS_OF_ID = 3'd3,
      OP_CLEAR     = 3'd4
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic exec;
      logic sweep_write;
      logic sweep_done;
      logic load_answer;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_BITS-1:0] op_code;
      logic               epoch_last;
      logic               sweep_last;
      logic               out_free;
   } status_type;

endpackage

`default_nettype wire

### design/rdq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module rdq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/rdq_ctrl.sv
// Controller state machine of the ring deque: sequences accept, execute,
// memory read wait and the table clearing sweep. Depends on rdq_pkg.
`default_nettype none

module rdq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire rdq_pkg::status_type status,
   output rdq_pkg::cmd_type         cmd
);
   import rdq_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_EXEC,
      ST_WAIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (status.sweep_last) begin
               cmd.sweep_done = 1'b1;
               state_in       = ST_IDLE;
               ready_in       = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_tvalid && ready_ff) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
               ready_in      = 1'b0;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            case (status.op_code)
               OP_ID_AT_POS, OP_POS_OF_ID: begin
                  state_in = ST_WAIT;
               end
               OP_CLEAR: begin
                  // Once the epoch tag runs out the id table is swept back to tag zero.
                  if (status.epoch_last) begin
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_IDLE;
                     ready_in = 1'b1;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end
            endcase
         end
         ST_WAIT: begin
            if (status.out_free) begin
               cmd.load_answer = 1'b1;
               state_in        = ST_IDLE;
               ready_in        = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

`default_nettype wire

### design/rdq_dp.sv
// Datapath of the ring deque: pointers, epoch tag, sweep counter, slot store,
// id-to-slot table and the result register. Depends on rdq_pkg and rdq_ram.
`default_nettype none

module rdq_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [rdq_pkg::OP_BITS-1:0]         req_operation,
   input  wire logic                                req_at_back,
   input  wire logic [rdq_pkg::VALUE_BITS-1:0]      req_operand_value,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [rdq_pkg::ANSWER_BITS-1:0]     rsp_answer,
   input  wire rdq_pkg::cmd_type                    cmd,
   output rdq_pkg::status_type                      status
);
   import rdq_pkg::*;

   // Latched transaction.
   logic [OP_BITS-1:0]    op_ff;
   logic                  back_ff;
   logic [VALUE_BITS-1:0] val_ff;

   logic [PTR_BITS-1:0]   front_ff, front_in;
   logic [PTR_BITS-1:0]   back_ptr_ff, back_ptr_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [ID_BITS-1:0]    sweep_ff, sweep_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANSWER_BITS-1:0] answer_ff;

   logic [ID_BITS-1:0]    item_id;
   logic [PTR_BITS-1:0]   front_dec;
   logic [PTR_BITS-1:0]   pos_slot;
   logic                  is_push;

   logic                  store_we;
   logic [PTR_BITS-1:0]   store_waddr;
   logic [ID_BITS-1:0]    store_rdata;

   logic                  tbl_we;
   logic [ID_BITS-1:0]    tbl_waddr;
   logic [TBL_BITS-1:0]   tbl_wdata;
   logic [TBL_BITS-1:0]   tbl_rdata;

   logic                  mapped;
   logic [PTR_BITS-1:0]   id_slot;
   logic [PTR_BITS:0]     distance;
   logic [ANSWER_BITS-1:0] answer_in;

   assign item_id   = ID_BITS'(val_ff);
   assign front_dec = front_ff - PTR_BITS'(1);
   // Position p from the front sits at front + p - 1, modulo the ring size.
   assign pos_slot  = front_ff + PTR_BITS'(val_ff) - PTR_BITS'(1);
   assign is_push   = cmd.exec && (op_ff == OP_PUSH);

   assign store_we    = is_push;
   assign store_waddr = back_ff ? back_ptr_ff : front_dec;

   // Table entries carry the epoch of their push; a stale epoch means unmapped.
   always_comb begin
      tbl_we    = is_push || cmd.sweep_write;
      tbl_waddr = cmd.sweep_write ? sweep_ff : item_id;
      tbl_wdata = cmd.sweep_write ? '0 : {epoch_ff, store_waddr};
   end

   rdq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (item_id),
      .rd_addr (pos_slot),
      .rd_data (store_rdata)
   );

   rdq_ram #(
      .WIDTH (TBL_BITS),
      .DEPTH (ID_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (item_id),
      .rd_data (tbl_rdata)
   );

   always_comb begin
      mapped   = (tbl_rdata[TBL_BITS-1:PTR_BITS] == epoch_ff);
      id_slot  = mapped ? tbl_rdata[PTR_BITS-1:0] : '0;
      distance = {1'b0, id_slot - front_ff} + (PTR_BITS + 1)'(1);
      if (op_ff == OP_ID_AT_POS) begin
         answer_in = ANSWER_BITS'(store_rdata);
      end else begin
         answer_in = ANSWER_BITS'(distance);
      end
   end

   always_comb begin
      front_in     = front_ff;
      back_ptr_in  = back_ptr_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_answer) begin
         rsp_valid_in = 1'b1;
      end
      if (cmd.sweep_write) begin
         sweep_in = sweep_ff + ID_BITS'(1);
      end
      if (cmd.sweep_done) begin
         epoch_in = EPOCH_BITS'(1);
      end
      if (cmd.exec) begin
         case (op_ff)
            OP_PUSH: begin
               if (back_ff) begin
                  back_ptr_in = back_ptr_ff + PTR_BITS'(1);
               end else begin
                  front_in = front_dec;
               end
            end
            OP_POP: begin
               if (back_ff) begin
                  back_ptr_in = back_ptr_ff - PTR_BITS'(1);
               end else begin
                  front_in = front_ff + PTR_BITS'(1);
               end
            end
            OP_CLEAR: begin
               front_in    = '0;
               back_ptr_in = '0;
               if (!(&epoch_ff)) begin
                  epoch_in = epoch_ff + EPOCH_BITS'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ptr_ff  <= '0;
         epoch_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ptr_ff  <= back_ptr_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_operation;
         back_ff <= req_at_back;
         val_ff  <= req_operand_value;
      end
      if (cmd.load_answer) begin
         answer_ff <= answer_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_answer = answer_ff;

   assign status.op_code    = op_ff;
   assign status.epoch_last = &epoch_ff;
   assign status.sweep_last = &sweep_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

### design/ring_deque_with_id_position_lookup.sv
// Top level of the ring deque of ids with id-to-position lookup.
// Joins the controller (rdq_ctrl) and the datapath (rdq_dp); uses rdq_pkg.
//
//   Channel   Direction  Payload
//   req_*     in         tdata: operand_value; tuser: operation, at_back
//   rsp_*     out        tdata: answer (one per query transaction)
//
// Push, pop, clear and ignored codes pass through an accept state, then an execute state.
// Queries add a wait state for the registered read of the slot store
// or the id table RAM, after which the answer is loaded into the output register.
// After reset, and after every 63rd clear, the block sweeps the 65536-entry id
// table with req_tready low, so that old epoch tags cannot alias.
// A stalled result holds in the output register; the next transaction is still
// accepted and only waits if it is a query that needs that register.
`default_nettype none

module ring_deque_with_id_position_lookup (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] operand_value
   input  wire logic [3:0]  req_tuser,   // [2:0] operation, [3] at_back
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata    // [15:0] answer
);
   import rdq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The controller sequences each transaction; it never touches payload bits.
   rdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the pointers, both memories and the result register.
   rdq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_tuser[OP_BITS-1:0]),
      .req_at_back       (req_tuser[OP_BITS]),
      .req_operand_value (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_answer        (rsp_tdata),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

`default_nettype wire
